// ===== rtl/csmab_pkg.sv =====
// ----------------------------------------------------------------------------
// csmab_pkg
// Types and constants shared by the CSMA/CA backoff and ACK retry controller.
// ----------------------------------------------------------------------------
package csmab_pkg;

  // event kinds on the input channel; unlisted codes behave as idle
  localparam logic [2:0] KIND_IDLE      = 3'd0;
  localparam logic [2:0] KIND_CLEAR     = 3'd1;
  localparam logic [2:0] KIND_FRAME_OK  = 3'd2;
  localparam logic [2:0] KIND_FRAME_BAD = 3'd3;
  localparam logic [2:0] KIND_SEND      = 3'd4;

  // completion codes
  localparam logic [1:0] CMPL_NONE = 2'd0;
  localparam logic [1:0] CMPL_OK   = 2'd1;
  localparam logic [1:0] CMPL_FAIL = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DIFS        = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_MAX_RETRY   = 2'd2;

  // configuration reset values
  localparam logic [7:0] DIFS_RESET        = 8'd12;
  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd60;
  localparam logic [3:0] MAX_RETRY_RESET   = 4'd7;

  localparam logic [7:0] BACKOFF_MAX = 8'd255;

  typedef enum logic [1:0] {
    MODE_RX      = 2'd0,
    MODE_TX      = 2'd1,
    MODE_WAITACK = 2'd2
  } mode_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        ack_for_me;
    logic        packet_waiting;
    logic        packet_sendable;
    logic        need_ack;
    logic        tx_ok;
    logic [14:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       start_tx;
    logic [1:0] complete;
  } out_item_t;

  typedef struct packed {
    logic [7:0] difs_slots;
    logic [7:0] ack_timeout_slots;
    logic [3:0] max_retry;
  } cfg_regs_t;

  typedef struct packed {
    mode_t      mac_mode;
    logic [8:0] wait_count;
    logic       reload_wait;
    logic [7:0] backoff_slots;
    logic       pending_valid;
    logic [4:0] retry_count;
  } mac_state_t;

endpackage

// ===== rtl/csmab_step.sv =====
// ----------------------------------------------------------------------------
// csmab_step
// Next-state and result logic for one event of the access controller.
// ----------------------------------------------------------------------------
module csmab_step (
  input  csmab_pkg::cfg_regs_t  cfg,
  input  csmab_pkg::mac_state_t cur,
  input  csmab_pkg::in_item_t   item,
  input  logic [7:0]            rnd_mod,
  input  logic [7:0]            rnd2_mod,
  output csmab_pkg::mac_state_t nxt,
  output csmab_pkg::out_item_t  res
);

  always_comb begin
    csmab_pkg::mac_state_t st;
    logic       start;
    logic [1:0] cmpl;
    logic       have;
    logic       sendable;
    logic       wants_ack;
    logic [4:0] retry;
    logic [8:0] wc;
    logic [8:0] dbl;
    logic [7:0] frozen;

    st        = cur;
    start     = 1'b0;
    cmpl      = csmab_pkg::CMPL_NONE;
    have      = 1'b0;
    sendable  = 1'b0;
    wants_ack = 1'b0;
    retry     = cur.retry_count;
    wc        = cur.wait_count;
    dbl       = {cur.backoff_slots, 1'b0};
    frozen    = cur.backoff_slots;

    if (cur.mac_mode == csmab_pkg::MODE_TX) begin
      if (item.kind == csmab_pkg::KIND_SEND) begin
        if (cur.pending_valid) begin
          // retry of the kept packet
          st.pending_valid = 1'b0;
          have      = 1'b1;
          sendable  = 1'b1;
          wants_ack = 1'b1;
        end else if (item.packet_waiting) begin
          have      = 1'b1;
          sendable  = item.packet_sendable;
          wants_ack = item.need_ack;
          retry     = 5'd0;
        end
        // every send opportunity leaves transmit mode
        st.mac_mode    = csmab_pkg::MODE_RX;
        st.reload_wait = 1'b1;
        if (have) begin
          if (!sendable) begin
            cmpl = csmab_pkg::CMPL_FAIL;
          end else if (retry > {1'b0, cfg.max_retry}) begin
            cmpl = csmab_pkg::CMPL_FAIL;
          end else begin
            start = 1'b1;
            retry = retry + 5'd1;
            if (!item.tx_ok) begin
              cmpl = csmab_pkg::CMPL_FAIL;
            end else if (wants_ack) begin
              st.pending_valid = 1'b1;
              st.mac_mode      = csmab_pkg::MODE_WAITACK;
            end else begin
              cmpl = csmab_pkg::CMPL_OK;
            end
          end
        end
        st.retry_count   = retry;
        st.backoff_slots = rnd_mod;
      end
    end else begin
      if (cur.reload_wait) begin
        st.reload_wait = 1'b0;
        if (cur.mac_mode == csmab_pkg::MODE_RX) begin
          wc = {1'b0, cfg.difs_slots} + {1'b0, cur.backoff_slots};
        end else begin
          wc = {1'b0, cfg.ack_timeout_slots};
        end
      end
      st.wait_count = wc;
      if (item.kind == csmab_pkg::KIND_CLEAR) begin
        if (wc != 9'd0) begin
          st.wait_count = wc - 9'd1;
        end else if (cur.mac_mode == csmab_pkg::MODE_WAITACK) begin
          // ack timeout: redraw and go back to contention
          st.backoff_slots = rnd2_mod;
          st.mac_mode      = csmab_pkg::MODE_RX;
          st.reload_wait   = 1'b1;
        end else begin
          st.mac_mode    = csmab_pkg::MODE_TX;
          st.reload_wait = 1'b1;
        end
      end else if (item.kind == csmab_pkg::KIND_FRAME_OK ||
                   item.kind == csmab_pkg::KIND_FRAME_BAD) begin
        if (item.kind == csmab_pkg::KIND_FRAME_OK && item.ack_for_me &&
            cur.pending_valid) begin
          st.pending_valid = 1'b0;
          cmpl = csmab_pkg::CMPL_OK;
        end
        if (cur.mac_mode == csmab_pkg::MODE_WAITACK) begin
          st.backoff_slots = dbl[8] ? csmab_pkg::BACKOFF_MAX : dbl[7:0];
          st.mac_mode      = csmab_pkg::MODE_RX;
          st.reload_wait   = 1'b1;
        end else begin
          // freeze whatever backoff is left
          if (wc < {1'b0, cur.backoff_slots}) begin
            frozen = wc[7:0];
          end
          st.backoff_slots = frozen;
          st.wait_count    = {1'b0, cfg.difs_slots} + {1'b0, frozen};
        end
      end
    end

    nxt          = st;
    res.mode     = st.mac_mode;
    res.start_tx = start;
    res.complete = cmpl;
  end

endmodule

// ===== rtl/csma_backoff_ack_controller.sv =====
// ----------------------------------------------------------------------------
// csma_backoff_ack_controller
// CSMA/CA medium-access controller with slot backoff and ACK retry.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | csmab_pkg::in_item_t
//  out_    | output    | out_valid/out_stall| csmab_pkg::out_item_t
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  one event per cycle sustained unless out_stall holds the pipeline; events
//  pass from the input register to the result register. the input stage
//  forms the backoff quotient, the second stage finishes the remainder and
//  runs the step logic. rst_n is synchronous; it clears mode and counters
//  and loads the configuration reset values. out_stall holds the result
//  register and stalls the input once both stages are full.
// ----------------------------------------------------------------------------
module csma_backoff_ack_controller #(
  parameter int BACKOFF_WINDOW = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  csmab_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output csmab_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data
);

  // reciprocal for the modulo by the window
  localparam int RECIP_SHIFT = 23;
  localparam int PROD_W      = 15 + RECIP_SHIFT;
  localparam logic [RECIP_SHIFT-1:0] RECIP_MUL =
    RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + 64'(BACKOFF_WINDOW) - 64'd1) /
                 64'(BACKOFF_WINDOW));
  localparam logic [15:0] WIN16 = 16'(BACKOFF_WINDOW);
  localparam logic [8:0]  WIN9  = 9'(BACKOFF_WINDOW);

  csmab_pkg::cfg_regs_t  cfg_r;
  csmab_pkg::mac_state_t state_r;
  csmab_pkg::mac_state_t state_nxt;
  csmab_pkg::in_item_t   in_r;
  csmab_pkg::out_item_t  out_r;
  csmab_pkg::out_item_t  res;
  logic                  s1_valid_r;
  logic                  out_valid_r;
  logic [14:0]           quot_r;
  logic                  in_accept;
  logic                  s1_adv;
  logic [PROD_W-1:0]     prod;
  logic [15:0]           qw;
  logic [15:0]           rem16;
  logic [15:0]           rem_fix;
  logic [7:0]            rnd_mod;
  logic [8:0]            dbl;
  logic [8:0]            dbl_fix;
  logic [7:0]            rnd2_mod;

  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // first half of the modulo: quotient estimate
  assign prod = PROD_W'(in_data.random_value) * PROD_W'(RECIP_MUL);

  // second half: remainder with one correction step
  assign qw      = 16'({1'b0, quot_r} * WIN16);
  assign rem16   = {1'b0, in_r.random_value} - qw;
  assign rem_fix = (rem16 >= WIN16) ? rem16 - WIN16 : rem16;
  assign rnd_mod = rem_fix[7:0];
  // (2*x) mod w from x mod w
  assign dbl      = {rnd_mod, 1'b0};
  assign dbl_fix  = (dbl >= WIN9) ? dbl - WIN9 : dbl;
  assign rnd2_mod = dbl_fix[7:0];

  csmab_step u_step (
    .cfg      (cfg_r),
    .cur      (state_r),
    .item     (in_r),
    .rnd_mod  (rnd_mod),
    .rnd2_mod (rnd2_mod),
    .nxt      (state_nxt),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.difs_slots        <= csmab_pkg::DIFS_RESET;
      cfg_r.ack_timeout_slots <= csmab_pkg::ACK_TIMEOUT_RESET;
      cfg_r.max_retry         <= csmab_pkg::MAX_RETRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        csmab_pkg::CFG_DIFS:        cfg_r.difs_slots        <= cfg_data;
        csmab_pkg::CFG_ACK_TIMEOUT: cfg_r.ack_timeout_slots <= cfg_data;
        csmab_pkg::CFG_MAX_RETRY:   cfg_r.max_retry         <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r   <= in_data;
      quot_r <= prod[RECIP_SHIFT +: 15];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r           <= 1'b0;
      state_r.mac_mode      <= csmab_pkg::MODE_RX;
      state_r.wait_count    <= 9'd0;
      state_r.reload_wait   <= 1'b1;
      state_r.backoff_slots <= 8'd0;
      state_r.pending_valid <= 1'b0;
      state_r.retry_count   <= 5'd0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_r <= res;
    end
  end

endmodule
